### hdl/hsit_pkg.sv
// ----------------------------------------------------------------------------
// hsit_pkg
// Shared constants and types for the hashed string intern table core.
// ----------------------------------------------------------------------------
package hsit_pkg;

    localparam int unsigned TABLE_ENTRIES = 256;
    localparam int unsigned LENGTH_BITS   = 16;
    localparam int unsigned IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int unsigned CNT_W         = IDX_W + 1;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX   = '1;
    localparam logic [31:0]            FNV_BASIS = 32'd2166136261;
    localparam logic [31:0]            FNV_PRIME = 32'd16777619;

    typedef enum logic [1:0] {
        ST_FOUND     = 2'd0,
        ST_ADDED     = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_REJECT    = 2'd3
    } t_status;

    typedef struct packed {
        logic [31:0]            hash;
        logic [LENGTH_BITS-1:0] len;
        logic                   too_long;
    } t_str_info;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] count;
    } t_srch_res;

endpackage

### hdl/hsit_hash.sv
// ----------------------------------------------------------------------------
// hsit_hash
// FNV-1a byte accumulator: running hash, string length and overflow flag.
// ----------------------------------------------------------------------------
module hsit_hash (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_byte_en,
    input  logic [7:0]         i_byte,
    input  logic               i_clear,
    output hsit_pkg::t_str_info o_str
);

    logic [31:0]                      r_hash, n_hash;
    logic                             r_seen, n_seen;
    logic [hsit_pkg::LENGTH_BITS-1:0] r_len, n_len;
    logic                             r_too_long, n_too_long;
    logic [31:0]                      w_mix;

    assign w_mix = r_hash ^ {24'd0, i_byte};

    always_comb begin
        n_hash     = r_hash;
        n_seen     = r_seen;
        n_len      = r_len;
        n_too_long = r_too_long;
        if (i_byte_en) begin
            n_hash = w_mix * hsit_pkg::FNV_PRIME;
            n_seen = 1'b1;
            if (r_len == hsit_pkg::LEN_MAX) begin
                n_too_long = 1'b1;
            end else begin
                n_len = r_len + 1'b1;
            end
        end
    end

    // Report the string including the byte of this transaction.
    assign o_str.hash     = n_seen ? n_hash : 32'd0;
    assign o_str.len      = n_len;
    assign o_str.too_long = n_too_long;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_hash     <= hsit_pkg::FNV_BASIS;
            r_seen     <= 1'b0;
            r_len      <= '0;
            r_too_long <= 1'b0;
        end else begin
            r_hash     <= n_hash;
            r_seen     <= n_seen;
            r_len      <= n_len;
            r_too_long <= n_too_long;
        end
    end

endmodule

### hdl/hsit_search.sv
// ----------------------------------------------------------------------------
// hsit_search
// Hash store and linear scan: one stored hash read and compared per cycle.
// ----------------------------------------------------------------------------
module hsit_search (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [31:0]         i_key,
    input  logic                i_ack,
    input  logic                i_wr_en,
    output hsit_pkg::t_srch_res o_res
);

    localparam int unsigned IDX_W = hsit_pkg::IDX_W;
    localparam int unsigned CNT_W = hsit_pkg::CNT_W;

    logic [31:0]      r_mem [hsit_pkg::TABLE_ENTRIES];
    logic [31:0]      r_rdata;
    logic [31:0]      r_key;
    logic             r_busy;
    logic             r_done;
    logic             r_found;
    logic [IDX_W-1:0] r_idx;
    logic [CNT_W-1:0] r_scan;
    logic             r_pend;
    logic [IDX_W-1:0] r_pend_idx;
    logic [CNT_W-1:0] r_count;
    logic             w_rd_en;

    assign w_rd_en = r_busy && (r_scan < r_count);

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[r_count[IDX_W-1:0]] <= r_key;
        end
        if (w_rd_en) begin
            r_rdata <= r_mem[r_scan[IDX_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
            r_scan  <= '0;
            r_pend  <= 1'b0;
            r_count <= '0;
        end else begin
            if (i_start) begin
                r_busy <= 1'b1;
                r_done <= 1'b0;
                r_scan <= '0;
                r_pend <= 1'b0;
                r_key  <= i_key;
            end else if (r_busy) begin
                if (r_pend && (r_rdata == r_key)) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_found <= 1'b1;
                    r_idx   <= r_pend_idx;
                end else if (!r_pend && (r_scan >= r_count)) begin
                    r_busy  <= 1'b0;
                    r_done  <= 1'b1;
                    r_found <= 1'b0;
                    r_idx   <= '0;
                end else begin
                    r_pend     <= w_rd_en;
                    r_pend_idx <= r_scan[IDX_W-1:0];
                    if (w_rd_en) begin
                        r_scan <= r_scan + 1'b1;
                    end
                end
            end else if (i_ack) begin
                r_done <= 1'b0;
            end
            if (i_wr_en) begin
                r_count <= r_count + 1'b1;
            end
        end
    end

    assign o_res.done  = r_done;
    assign o_res.found = r_found;
    assign o_res.idx   = r_idx;
    assign o_res.count = r_count;

endmodule

### hdl/hashed_string_intern_table_core.sv
// ----------------------------------------------------------------------------
// hashed_string_intern_table_core
// FNV-1a 32-bit string hasher with a deduplicating table of stored hashes.
// ----------------------------------------------------------------------------
// Strings arrive one byte per transaction and hash at one byte per cycle.
// The transaction with tlast starts a scan of the hash store that reads and
// compares one stored hash per cycle through a single memory read port and
// stops at the first matching hash or after the last stored entry; no input
// is taken during the scan. The result waits in an output register and the
// next string may start while it is held. Find requests only report; add
// requests append unmatched hashes until the table holds TABLE_ENTRIES, and
// reject a string longer than LEN_MAX bytes.
module hashed_string_intern_table_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_axis_tuser,   // [0] req_type, [1] byte_valid
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // [7:0] entry_index, [39:8] byte_offset,
                                        // [71:40] string_hash
    output logic [1:0]  m_axis_tuser    // [1:0] status
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_SEARCH = 2'b10
    } t_state;

    t_state              r_state, n_state;
    hsit_pkg::t_str_info w_str;
    hsit_pkg::t_str_info r_str;
    hsit_pkg::t_srch_res w_res;
    logic                r_req;
    logic [31:0]         r_total;
    logic                r_m_valid;
    logic [1:0]          r_m_status;
    logic [7:0]          r_m_index;
    logic [31:0]         r_m_offset;
    logic [31:0]         r_m_hash;

    logic                w_accept;
    logic                w_last;
    logic                w_out_free;
    logic                w_commit;
    logic                w_wr_en;
    hsit_pkg::t_status   w_status;
    logic [7:0]          w_index;
    logic [33:0]         w_sum;
    logic [31:0]         w_total_next;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_last        = w_accept && s_axis_tlast;
    assign w_out_free    = !r_m_valid || m_axis_tready;
    assign w_commit      = (r_state == S_SEARCH) && w_res.done && w_out_free;

    hsit_hash u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte_en (w_accept && s_axis_tuser[1]),
        .i_byte    (s_axis_tdata),
        .i_clear   (w_last),
        .o_str     (w_str)
    );

    hsit_search u_search (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_last),
        .i_key   (w_str.hash),
        .i_ack   (w_commit),
        .i_wr_en (w_wr_en),
        .o_res   (w_res)
    );

    assign w_sum = {2'b00, r_total} + 34'(r_str.len) + 34'd1;
    assign w_total_next = (w_sum[33:32] != 2'b00) ? 32'hFFFF_FFFF : w_sum[31:0];

    always_comb begin
        w_status = hsit_pkg::ST_NOT_FOUND;
        w_index  = 8'd0;
        w_wr_en  = 1'b0;
        if (w_res.found) begin
            w_status = hsit_pkg::ST_FOUND;
            w_index  = 8'(w_res.idx);
        end else if (r_req) begin
            w_status = hsit_pkg::ST_NOT_FOUND;
        end else if ((w_res.count == hsit_pkg::CNT_W'(hsit_pkg::TABLE_ENTRIES))
                     || r_str.too_long) begin
            w_status = hsit_pkg::ST_REJECT;
        end else begin
            w_status = hsit_pkg::ST_ADDED;
            w_index  = 8'(w_res.count);
            w_wr_en  = w_commit;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_last) begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
            r_total   <= '0;
        end else begin
            r_state <= n_state;
            if (w_last) begin
                r_str <= w_str;
                r_req <= s_axis_tuser[0];
            end
            if (w_wr_en) begin
                r_total <= w_total_next;
            end
            if (w_commit) begin
                r_m_valid  <= 1'b1;
                r_m_status <= w_status;
                r_m_index  <= w_index;
                r_m_offset <= r_total;
                r_m_hash   <= r_str.hash;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_hash, r_m_offset, r_m_index};
    assign m_axis_tuser  = r_m_status;

endmodule

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the hashed string intern table core.
// ----------------------------------------------------------------------------
// Strings of random bytes, empty strings, noise transactions and a long
// back-to-back string are streamed in, the table is filled to capacity,
// and every result is checked against a cycle-free model of the FNV-1a hash,
// the ordered table search and the running byte total.
module tb_top;

    localparam int CYCLE_LIMIT = 3_000_000;
    localparam int RANDOM_ITEMS = 300;

    typedef struct packed {
        logic       req;
        logic [7:0] data;
        logic       valid;
        logic       last;
        logic       burst;
        logic       drain;
    } t_byte_item;

    typedef struct packed {
        hsit_pkg::t_status status;
        logic [7:0]        index;
        logic [31:0]       offset;
        logic [31:0]       hash;
    } t_answer;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;   // [7:0] data_byte
    logic [1:0]  s_axis_tuser = '0;   // [0] req_type, [1] byte_valid
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;        // [7:0] entry_index, [39:8] byte_offset,
                                      // [71:40] string_hash
    logic [1:0]  m_axis_tuser;        // [1:0] status

    t_byte_item  byte_queue[$];
    t_answer     pending_answers[$];
    logic [7:0]  text_pool[$];
    int          text_start[$];
    int          text_len[$];
    int          stim_items = 0;
    int          error_count = 0;
    int          answers_seen = 0;
    int          cycle_count = 0;

    logic [31:0]                      m_hash = hsit_pkg::FNV_BASIS;
    logic                             m_seen = 1'b0;
    logic [hsit_pkg::LENGTH_BITS-1:0] m_len = '0;
    logic                             m_over = 1'b0;
    logic [31:0]                      m_store [hsit_pkg::TABLE_ENTRIES];
    int unsigned                      m_count = 0;
    logic [31:0]                      m_total = '0;

    t_byte_item tx_item;
    logic       tx_busy;
    logic       tx_calm = 1'b0;
    int         tx_gap = 0;
    logic       rx_calm = 1'b0;
    int         rx_wait = 0;
    int         rx_hold = 0;

    hashed_string_intern_table_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic intern_step(input t_byte_item it);
        t_answer     ans;
        logic [31:0] h;
        logic [32:0] sum;
        logic        hit;
        int unsigned idx;
        if (it.valid) begin
            m_hash = (m_hash ^ {24'd0, it.data}) * hsit_pkg::FNV_PRIME;
            m_seen = 1'b1;
            if (m_len == hsit_pkg::LEN_MAX) m_over = 1'b1;
            else m_len = m_len + 1'b1;
        end
        if (!it.last) return;
        h = m_seen ? m_hash : 32'd0;
        hit = 1'b0;
        idx = 0;
        for (int unsigned i = 0; i < m_count; i++) begin
            if (!hit && m_store[i] == h) begin
                hit = 1'b1;
                idx = i;
            end
        end
        ans.offset = m_total;
        ans.hash = h;
        if (hit) begin
            ans.status = hsit_pkg::ST_FOUND;
        end else if (it.req) begin
            ans.status = hsit_pkg::ST_NOT_FOUND;
        end else if (m_count >= hsit_pkg::TABLE_ENTRIES || m_over) begin
            ans.status = hsit_pkg::ST_REJECT;
        end else begin
            ans.status = hsit_pkg::ST_ADDED;
            idx = m_count;
            m_store[m_count] = h;
            m_count++;
            sum = {1'b0, m_total} + 33'(m_len) + 33'd1;
            m_total = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        end
        ans.index = idx[7:0];
        pending_answers.insert(pending_answers.size(), ans);
        m_hash = hsit_pkg::FNV_BASIS;
        m_seen = 1'b0;
        m_len = '0;
        m_over = 1'b0;
    endtask

    // Driver: hold each transaction until accepted, then draw the next gap.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap = 0;
        end else begin
            tx_busy = s_axis_tvalid;
            if (s_axis_tvalid && s_axis_tready) begin
                intern_step(tx_item);
                tx_busy = 1'b0;
                if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
                tx_gap = (tx_calm || tx_item.burst) ? 0 : $urandom_range(0, 14);
            end
            if (!tx_busy) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                end else if (byte_queue.size() > 0 &&
                             !(byte_queue[0].drain && pending_answers.size() > 0)) begin
                    tx_item = byte_queue.pop_front();
                    s_axis_tdata <= tx_item.data;
                    s_axis_tuser <= {tx_item.valid, tx_item.req};
                    s_axis_tlast <= tx_item.last;
                    tx_busy = 1'b1;
                end
            end
            s_axis_tvalid <= tx_busy;
        end
    end

    // Monitor: check each result transaction against the oldest prediction.
    always @(posedge i_clk) begin
        t_answer exp_ans;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_answers.size() == 0) begin
                    $error("unexpected result: status %0d hash %08h",
                           m_axis_tuser, m_axis_tdata[71:40]);
                    error_count++;
                end else begin
                    exp_ans = pending_answers.pop_front();
                    if (hsit_pkg::t_status'(m_axis_tuser) != exp_ans.status) begin
                        $error("status: expected %0d, got %0d", exp_ans.status, m_axis_tuser);
                        error_count++;
                    end
                    if (m_axis_tdata[7:0] != exp_ans.index) begin
                        $error("entry_index: expected %0d, got %0d",
                               exp_ans.index, m_axis_tdata[7:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[39:8] != exp_ans.offset) begin
                        $error("byte_offset: expected %0d, got %0d",
                               exp_ans.offset, m_axis_tdata[39:8]);
                        error_count++;
                    end
                    if (m_axis_tdata[71:40] != exp_ans.hash) begin
                        $error("string_hash: expected %08h, got %08h",
                               exp_ans.hash, m_axis_tdata[71:40]);
                        error_count++;
                    end
                end
                answers_seen++;
                if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
                rx_wait = rx_calm ? 0 : $urandom_range(0, 14);
                if (answers_seen == 60) rx_hold = 400;
            end else if (rx_hold > 0) begin
                rx_hold--;
            end else if (rx_wait > 0) begin
                rx_wait--;
            end
            m_axis_tready <= (rx_hold == 0 && rx_wait == 0);
        end
    end

    task automatic push_item(input logic req, input logic [7:0] data, input logic valid,
                             input logic last, input logic burst, input logic drain);
        t_byte_item it;
        it = '{req: req, data: data, valid: valid, last: last, burst: burst, drain: drain};
        byte_queue.insert(byte_queue.size(), it);
        if (valid || last) stim_items++;
    endtask

    task automatic new_text(input int count, input logic [7:0] lead_byte, input int tag);
        text_start.insert(text_start.size(), text_pool.size());
        text_len.insert(text_len.size(), count);
        for (int k = 0; k < count; k++) begin
            if (lead_byte != 8'h00 && k == 0)
                text_pool.insert(text_pool.size(), lead_byte);
            else if (lead_byte != 8'h00 && k == 1)
                text_pool.insert(text_pool.size(), tag[7:0]);
            else if (lead_byte != 8'h00 && k == 2)
                text_pool.insert(text_pool.size(), tag[15:8]);
            else
                text_pool.insert(text_pool.size(), 8'($urandom_range(0, 255)));
        end
    endtask

    // Noise transactions and a separate empty end transaction appear at random.
    task automatic push_text(input int sel, input logic req, input logic drain);
        logic lead;
        logic tail;
        int   first;
        int   count;
        lead = drain;
        first = text_start[sel];
        count = text_len[sel];
        tail = (count == 0) || ($urandom_range(0, 4) == 0);
        for (int k = 0; k < count; k++) begin
            if ($urandom_range(0, 9) == 0) begin
                push_item(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                          1'b0, 1'b0, 1'b0, lead);
                lead = 1'b0;
            end
            push_item((k == count - 1 && !tail) ? req : 1'($urandom_range(0, 1)),
                      text_pool[first + k], 1'b1, k == count - 1 && !tail, 1'b0, lead);
            lead = 1'b0;
        end
        if (tail) push_item(req, 8'($urandom_range(0, 255)), 1'b0, 1'b1, 1'b0, lead);
    endtask

    task automatic push_long(input int count, input logic req);
        for (int k = 0; k < count; k++)
            push_item(req, 8'($urandom_range(0, 255)), 1'b1, k == count - 1, 1'b1, k == 0);
    endtask

    initial begin
        int base;
        int sel;
        int count;
        // directed: empty strings, extreme bytes, repeat and miss
        new_text(0, 8'h00, 0);
        push_text(0, 1'b0, 1'b0);
        push_text(0, 1'b1, 1'b0);
        push_item(1'b1, 8'hFF, 1'b0, 1'b0, 1'b0, 1'b0);
        text_start.insert(text_start.size(), text_pool.size());
        text_len.insert(text_len.size(), 1);
        text_pool.insert(text_pool.size(), 8'h00);
        push_text(1, 1'b0, 1'b0);
        text_start.insert(text_start.size(), text_pool.size());
        text_len.insert(text_len.size(), 1);
        text_pool.insert(text_pool.size(), 8'hFF);
        push_text(2, 1'b0, 1'b0);
        new_text(2, 8'h00, 0);
        push_text(3, 1'b1, 1'b0);
        push_text(2, 1'b0, 1'b0);
        push_text(3, 1'b0, 1'b0);
        push_text(3, 1'b1, 1'b0);
        new_text(5, 8'h00, 0);
        push_text(4, 1'b1, 1'b1);
        // long string sent back to back
        push_long(40, 1'b0);
        // random strings, a third of them repeats
        base = stim_items;
        while (stim_items < base + RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                sel = $urandom_range(0, text_start.size() - 1);
            end else begin
                count = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40)
                                                     : $urandom_range(0, 6);
                new_text(count, 8'h00, 0);
                sel = text_start.size() - 1;
            end
            push_text(sel, 1'($urandom_range(0, 1)), $urandom_range(0, 49) == 0);
        end
        // fill the table with every one-byte string, then add and find against it
        for (int i = 0; i < 256; i++) begin
            push_item(1'b0, 8'(i), 1'b1, 1'b1, 1'b0, i == 0);
        end
        for (int i = 0; i < 30; i++) begin
            if ($urandom_range(0, 1) == 0) begin
                sel = $urandom_range(0, text_start.size() - 1);
            end else begin
                new_text($urandom_range(1, 6), 8'h00, 0);
                sel = text_start.size() - 1;
            end
            push_text(sel, 1'($urandom_range(0, 1)), 1'b0);
        end
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (byte_queue.size() > 0 || s_axis_tvalid || pending_answers.size() > 0)
            @(posedge i_clk);
        repeat (hsit_pkg::TABLE_ENTRIES + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
